>>> rtl/core/bhr_pkg.sv
// bhr_pkg: shared constants, types and helper functions of the box hessian response block
// no dependencies; imported by every other file of the block
`default_nettype none

package bhr_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int WINDOW_ROWS = 64;
  localparam int BASE_SIZE   = 9;
  localparam int ROW_PITCH   = MAX_WIDTH + 1;
  localparam int STORE_DEPTH = WINDOW_ROWS * ROW_PITCH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int SLOT_W      = $clog2(WINDOW_ROWS);
  localparam int NLOBES      = 10;
  localparam int NCORNERS    = 4 * NLOBES;
  localparam int MAX_SIZE    = WINDOW_ROWS - 1;

  // field widths
  localparam int PIX_W   = 8;
  localparam int INT_W   = 32;
  localparam int POS_W   = 10;
  localparam int COORD_W = 11;
  localparam int STEP_W  = 5;
  localparam int SC_W    = $clog2(MAX_SIZE + 1);
  localparam int WT_W    = 24;
  localparam int DERIV_W = 28;
  localparam int ACC_W   = 52;
  localparam int DET_W   = 35;
  localparam int TRACE_W = 29;
  localparam int CFG_W   = 11;

  // serial divider widths
  localparam int PDIV_W  = COORD_W;
  localparam int WDIV_W  = 19;
  localparam int WDEN_W  = 13;

  // 0.81 in q16 and the reciprocal of the base size in q16 (rounded up)
  localparam logic [15:0] K081_Q16 = 16'd53084;
  localparam int          RECIP_BASE = (65536 + BASE_SIZE - 1) / BASE_SIZE;

  typedef enum logic [1:0] {
    CFG_FILTER_SIZE  = 2'd0,
    CFG_SAMPLE_STEP  = 2'd1,
    CFG_IMAGE_WIDTH  = 2'd2,
    CFG_IMAGE_HEIGHT = 2'd3
  } cfg_idx_t;

  // one lobe of the 9x9 base pattern: corners in base units, weight magnitude and sign
  typedef struct packed {
    logic [3:0] x1;
    logic [3:0] y1;
    logic [3:0] x2;
    logic [3:0] y2;
    logic [1:0] mag;
    logic       neg;
  } lobe_def_t;

  // dxx lobes 0..2, dyy lobes 3..5, dxy lobes 6..9
  function automatic lobe_def_t lobe_def(input logic [3:0] k);
    lobe_def_t d;
    case (k)
      4'd0:    d = '{x1: 4'd0, y1: 4'd2, x2: 4'd3, y2: 4'd7, mag: 2'd1, neg: 1'b0};
      4'd1:    d = '{x1: 4'd3, y1: 4'd2, x2: 4'd6, y2: 4'd7, mag: 2'd2, neg: 1'b1};
      4'd2:    d = '{x1: 4'd6, y1: 4'd2, x2: 4'd9, y2: 4'd7, mag: 2'd1, neg: 1'b0};
      4'd3:    d = '{x1: 4'd2, y1: 4'd0, x2: 4'd7, y2: 4'd3, mag: 2'd1, neg: 1'b0};
      4'd4:    d = '{x1: 4'd2, y1: 4'd3, x2: 4'd7, y2: 4'd6, mag: 2'd2, neg: 1'b1};
      4'd5:    d = '{x1: 4'd2, y1: 4'd6, x2: 4'd7, y2: 4'd9, mag: 2'd1, neg: 1'b0};
      4'd6:    d = '{x1: 4'd1, y1: 4'd1, x2: 4'd4, y2: 4'd4, mag: 2'd1, neg: 1'b0};
      4'd7:    d = '{x1: 4'd5, y1: 4'd1, x2: 4'd8, y2: 4'd4, mag: 2'd1, neg: 1'b1};
      4'd8:    d = '{x1: 4'd1, y1: 4'd5, x2: 4'd4, y2: 4'd8, mag: 2'd1, neg: 1'b1};
      4'd9:    d = '{x1: 4'd5, y1: 4'd5, x2: 4'd8, y2: 4'd8, mag: 2'd1, neg: 1'b0};
      default: d = '{x1: 4'd0, y1: 4'd0, x2: 4'd0, y2: 4'd0, mag: 2'd0, neg: 1'b0};
    endcase
    return d;
  endfunction

  // integral row r lives in slot r mod WINDOW_ROWS, each slot one pitch long
  function automatic logic [ADDR_W-1:0] ram_addr(input logic [COORD_W-1:0] row,
                                                 input logic [COORD_W-1:0] col);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(row[SLOT_W-1:0]) * ADDR_W'(ROW_PITCH);
    return base + ADDR_W'(col);
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/bhr_if.sv
// bhr_in_if / bhr_out_if: valid-ready channels for pixels in and responses out
// depends on bhr_pkg for field widths
`default_nettype none

interface bhr_in_if import bhr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface bhr_out_if import bhr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DET_W-1:0]   det_response;
  logic signed [TRACE_W-1:0] trace_response;
  logic [POS_W-1:0]          out_row;
  logic [POS_W-1:0]          out_col;

  modport source (output valid, output det_response, output trace_response,
                  output out_row, output out_col, input ready);
  modport sink   (input valid, input det_response, input trace_response,
                  input out_row, input out_col, output ready);
endinterface

`default_nettype wire

>>> rtl/core/bhr_ram.sv
// bhr_ram: integral image window store, one write and one registered read port
// depends on bhr_pkg for depth and address width
`default_nettype none

module bhr_ram import bhr_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [INT_W-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [INT_W-1:0]  rdata
);

  logic [INT_W-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/bhr_pdiv.sv
// bhr_pdiv: radix-2 restoring divider for sample positions, one quotient bit per cycle
// depends on bhr_pkg for widths
`default_nettype none

module bhr_pdiv import bhr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [PDIV_W-1:0]  dividend,
  input  logic [STEP_W-1:0]  divisor,
  output logic               done,
  output logic [PDIV_W-1:0]  quo,
  output logic [STEP_W-1:0]  rem
);

  localparam int CNT_W = $clog2(PDIV_W);

  logic              run_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [PDIV_W-1:0] quo_r, quo_nxt;
  logic [STEP_W-1:0] rem_r, rem_nxt;
  logic [STEP_W-1:0] div_r;
  logic [STEP_W:0]   shifted;
  logic [STEP_W+1:0] diff;

  always_comb begin
    shifted = {rem_r, quo_r[PDIV_W-1]};
    diff    = {1'b0, shifted} - {2'b00, div_r};
    if (!diff[STEP_W+1]) begin
      rem_nxt = diff[STEP_W-1:0];
      quo_nxt = {quo_r[PDIV_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[STEP_W-1:0];
      quo_nxt = {quo_r[PDIV_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(PDIV_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (run_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

>>> rtl/core/bhr_pattern.sv
// bhr_pattern: rescales the 9x9 box pattern to the filter size and derives q16 lobe weights
// depends on bhr_pkg for the base lobe table and widths
`default_nettype none

module bhr_pattern import bhr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [SC_W-1:0]        size,
  input  logic [3:0]             x_idx,
  input  logic [3:0]             y_idx,
  input  logic [3:0]             wt_idx,
  output logic                   busy,
  output logic [SC_W-1:0]        sc_x,
  output logic [SC_W-1:0]        sc_y,
  output logic signed [WT_W-1:0] wt
);

  localparam int WCNT_W = $clog2(WDIV_W);
  localparam int AREA_W = 2 * SC_W;

  typedef enum logic [2:0] {
    P_IDLE, P_SCALE, P_LOBE, P_SPAN, P_AREA, P_DIV, P_STORE
  } pstate_t;

  pstate_t             state_r;
  logic [3:0]          v_r;
  logic [WCNT_W-1:0]   bit_r;
  logic [SC_W-1:0]     x1_r, y1_r, w_r, h_r;
  logic [WDIV_W-1:0]   num_r, num_nxt;
  logic [WDEN_W-1:0]   rem_r, rem_nxt, den_r;
  logic [SC_W-1:0]     sc_x_r [NLOBES];
  logic [SC_W-1:0]     sc_y_r [NLOBES];
  logic signed [WT_W-1:0] wt_r [NLOBES];

  lobe_def_t           def;
  logic [3:0]          xa, ya;
  logic [SC_W-1:0]     xv, yv;
  logic [9:0]          base_x;
  logic [22:0]         scaled;
  logic [AREA_W-1:0]   area;
  logic [WDEN_W:0]     shifted;
  logic [WDEN_W+1:0]   diff;

  assign def = lobe_def(v_r);

  always_comb begin
    xa = x_idx;
    ya = y_idx;
    if (state_r == P_LOBE) begin
      xa = def.x1;
      ya = def.y1;
    end else if (state_r == P_SPAN) begin
      xa = def.x2;
      ya = def.y2;
    end
  end

  assign xv   = sc_x_r[xa];
  assign yv   = sc_y_r[ya];
  assign sc_x = xv;
  assign sc_y = yv;
  assign wt   = wt_r[wt_idx];
  assign busy = (state_r != P_IDLE);

  // v * size / 9 by reciprocal multiply, exact for the products that occur here
  assign base_x = 10'(v_r) * 10'(size);
  assign scaled = 23'(base_x) * 23'(RECIP_BASE);
  assign area   = AREA_W'(w_r) * AREA_W'(h_r);

  always_comb begin
    shifted = {rem_r, num_r[WDIV_W-1]};
    diff    = {1'b0, shifted} - {2'b00, den_r};
    if (!diff[WDEN_W+1]) begin
      rem_nxt = diff[WDEN_W-1:0];
      num_nxt = {num_r[WDIV_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[WDEN_W-1:0];
      num_nxt = {num_r[WDIV_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= P_SCALE;
      v_r     <= '0;
      bit_r   <= '0;
    end else if (start) begin
      state_r <= P_SCALE;
      v_r     <= '0;
      bit_r   <= '0;
    end else begin
      case (state_r)
        P_IDLE: begin
        end
        P_SCALE: begin
          sc_x_r[v_r] <= scaled[16 +: SC_W];
          sc_y_r[v_r] <= scaled[16 +: SC_W];
          if (v_r == 4'(NLOBES - 1)) begin
            v_r     <= '0;
            state_r <= P_LOBE;
          end else begin
            v_r <= v_r + 1'b1;
          end
        end
        P_LOBE: begin
          x1_r    <= xv;
          y1_r    <= yv;
          state_r <= P_SPAN;
        end
        P_SPAN: begin
          w_r     <= xv - x1_r;
          h_r     <= yv - y1_r;
          state_r <= P_AREA;
        end
        P_AREA: begin
          // round(2^16 * mag / area), half up
          num_r   <= WDIV_W'({def.mag, 17'b0}) + WDIV_W'(area);
          den_r   <= WDEN_W'({area, 1'b0});
          rem_r   <= '0;
          bit_r   <= '0;
          state_r <= P_DIV;
        end
        P_DIV: begin
          num_r <= num_nxt;
          rem_r <= rem_nxt;
          bit_r <= bit_r + 1'b1;
          if (bit_r == WCNT_W'(WDIV_W - 1)) begin
            state_r <= P_STORE;
          end
        end
        P_STORE: begin
          wt_r[v_r] <= def.neg ? -WT_W'(num_r) : WT_W'(num_r);
          if (v_r == 4'(NLOBES - 1)) begin
            state_r <= P_IDLE;
          end else begin
            v_r     <= v_r + 1'b1;
            state_r <= P_LOBE;
          end
        end
        default: state_r <= P_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/bhr_det.sv
// bhr_det: determinant and trace of the box hessian from q16 derivatives
// depends on bhr_pkg for widths and the 0.81 weight
`default_nettype none

module bhr_det import bhr_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [DERIV_W-1:0] dxx,
  input  logic signed [DERIV_W-1:0] dyy,
  input  logic signed [DERIV_W-1:0] dxy,
  output logic                      done,
  output logic signed [DET_W-1:0]   det,
  output logic signed [TRACE_W-1:0] trace
);

  localparam int PROD_W = 2 * DERIV_W;
  localparam int SQH_W  = PROD_W - 16 - 1;
  localparam int T_W    = SQH_W + 16;
  localparam int DIFF_W = PROD_W + 2;
  localparam int Q_W    = DIFF_W - 20;
  localparam logic signed [Q_W-1:0] DET_HI = Q_W'((64'sd1 <<< (DET_W - 1)) - 1);
  localparam logic signed [Q_W-1:0] DET_LO = -DET_HI - 1'sb1;

  logic                      v1_r, v2_r, v3_r;
  logic signed [PROD_W-1:0]  pxy_r, pxy2_r;
  logic signed [PROD_W-1:0]  sq_r;
  logic [T_W-1:0]            t_r;
  logic signed [TRACE_W-1:0] tr_r, tr2_r, tr3_r;
  logic signed [DET_W-1:0]   det_r;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [Q_W-1:0]     q;

  always_comb begin
    diff = DIFF_W'(pxy2_r) - $signed({2'b00, t_r}) + DIFF_W'(64'sd1 <<< 19);
    q    = Q_W'(diff >>> 20);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    pxy_r  <= dxx * dyy;
    sq_r   <= dxy * dxy;
    tr_r   <= TRACE_W'(dxx) + TRACE_W'(dyy);
    pxy2_r <= pxy_r;
    tr2_r  <= tr_r;
    t_r    <= T_W'(sq_r[16 +: SQH_W]) * T_W'(K081_Q16);
    tr3_r  <= tr2_r;
    if (q > DET_HI) begin
      det_r <= DET_HI[DET_W-1:0];
    end else if (q < DET_LO) begin
      det_r <= DET_LO[DET_W-1:0];
    end else begin
      det_r <= q[DET_W-1:0];
    end
  end

  assign done  = v3_r;
  assign det   = det_r;
  assign trace = tr3_r;

endmodule

`default_nettype wire

>>> rtl/core/box_hessian_response.sv
// box_hessian_response: top level of the streaming fast-hessian box filter
// depends on bhr_pkg, bhr_if, bhr_ram, bhr_pdiv, bhr_pattern, bhr_det
`default_nettype none

// Pixels enter in raster order, one transaction each, and build a rolling integral
// image of the last 64 rows in one memory (one write and one read port, read data
// registered). Every pixel costs a read of the integral entry above it and a write,
// so a pixel whose filter window is not yet complete passes through the write state
// and back to idle. Once the window is complete, three serial dividers work out
// the sample phase and the output coordinates. A sampled pixel then reads the 40
// box corners through the single memory read port, one per cycle, and finishes
// through the weight multiply, the derivative accumulators and the determinant
// pipeline. The block works on one pixel at a time; a finished response waits in
// the output register while the next pixel is taken. After reset and after each
// write of filter_size the pattern is rescaled and the lobe weights divided out,
// during which no pixel is taken. The integral store has no clearing pass: its
// contents are undefined until the image has written them.
module box_hessian_response import bhr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_idx,
  input  logic [CFG_W-1:0] cfg_data,
  bhr_in_if.sink           in_if,
  bhr_out_if.source        out_if
);

  typedef enum logic [2:0] {
    S_IDLE, S_WRITE, S_DIV, S_READ, S_DRAIN, S_START, S_DET, S_OUT
  } state_t;

  // tag that travels with each corner read
  typedef struct packed {
    logic       vld;
    logic       last;
    logic       zero;
    logic       neg;
    logic [1:0] corner;
    logic [3:0] lobe;
  } rd_tag_t;

  localparam logic signed [ACC_W-1:0] D_HI = ACC_W'((64'sd1 <<< (DERIV_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] D_LO = -D_HI - 1'sb1;
  localparam int                      PROD_W = INT_W + 1 + WT_W;

  // configuration registers
  logic [7:0]         filter_r;
  logic [STEP_W-1:0]  step_r;
  logic [COORD_W-1:0] width_r, height_r;
  logic               rebuild_r;

  // effective geometry
  logic [SC_W-1:0]    size_e;
  logic [STEP_W-1:0]  step_e;
  logic [COORD_W-1:0] width_e, height_e;

  // pixel tracking
  state_t             state_r;
  logic [POS_W-1:0]   prow_r, pcol_r, cur_row_r, cur_col_r;
  logic [INT_W-1:0]   rsum_r;
  logic [COORD_W-1:0] top_r, left_r;
  logic [5:0]         idx_r;
  logic [POS_W-1:0]   orow_r, ocol_r;

  // corner pipeline
  rd_tag_t                   tag0, tag_a_r;
  logic [INT_W-1:0]          box_r, box_nxt, term;
  logic                      bvld_r, blast_r;
  logic [3:0]                blobe_r;
  logic [INT_W-1:0]          boxv_r;
  logic signed [WT_W-1:0]    wt_b_r;
  logic                      cvld_r, clast_r;
  logic [3:0]                clobe_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_xx_r, acc_yy_r, acc_xy_r, prod_ext;

  // output register
  logic                      out_valid_r;
  logic signed [DET_W-1:0]   det_q_r;
  logic signed [TRACE_W-1:0] tr_q_r;
  logic [POS_W-1:0]          orow_q_r, ocol_q_r;

  // submodule wiring
  logic                      in_ready, accept, out_load;
  logic [POS_W-1:0]          row_e, col_e;
  logic [INT_W-1:0]          rsum_e;
  logic [COORD_W-1:0]        r1, c1, rrow, rcol;
  logic                      in_win;
  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_waddr, ram_raddr;
  logic [INT_W-1:0]          ram_wdata, ram_rdata;
  logic                      div_start, rdiv_done, cdiv_done, mdiv_done;
  logic [PDIV_W-1:0]         rq, cq, mq;
  logic [STEP_W-1:0]         rrem, crem, mrem;
  logic                      pat_busy;
  logic [3:0]                x_idx, y_idx;
  logic [SC_W-1:0]           sc_xv, sc_yv;
  logic signed [WT_W-1:0]    wt;
  lobe_def_t                 def;
  logic                      det_start, det_done;
  logic signed [DET_W-1:0]   det_v;
  logic signed [TRACE_W-1:0] tr_v;

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_r  <= 8'(BASE_SIZE);
      step_r    <= STEP_W'(1);
      width_r   <= COORD_W'(640);
      height_r  <= COORD_W'(480);
      rebuild_r <= 1'b0;
    end else begin
      rebuild_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_FILTER_SIZE: begin
            filter_r  <= cfg_data[7:0];
            rebuild_r <= 1'b1;
          end
          CFG_SAMPLE_STEP:  step_r   <= cfg_data[STEP_W-1:0];
          CFG_IMAGE_WIDTH:  width_r  <= cfg_data;
          CFG_IMAGE_HEIGHT: height_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // out-of-range settings are clamped
  always_comb begin
    if (filter_r < 8'(BASE_SIZE)) begin
      size_e = SC_W'(BASE_SIZE);
    end else if (filter_r > 8'(MAX_SIZE)) begin
      size_e = SC_W'(MAX_SIZE);
    end else begin
      size_e = filter_r[SC_W-1:0];
    end
    step_e = (step_r == '0) ? STEP_W'(1) : step_r;
    if (width_r < COORD_W'(2)) begin
      width_e = COORD_W'(2);
    end else if (width_r > COORD_W'(MAX_WIDTH)) begin
      width_e = COORD_W'(MAX_WIDTH);
    end else begin
      width_e = width_r;
    end
    if (height_r < COORD_W'(2)) begin
      height_e = COORD_W'(2);
    end else if (height_r > COORD_W'(1024)) begin
      height_e = COORD_W'(1024);
    end else begin
      height_e = height_r;
    end
  end

  // ---------------------------------------------------------------- pixel intake
  assign in_ready    = (state_r == S_IDLE) && !pat_busy && !rebuild_r;
  assign in_if.ready = in_ready;
  assign accept      = in_if.valid && in_ready;

  // frame_start restarts the counters for this pixel
  assign row_e  = in_if.frame_start ? '0 : prow_r;
  assign col_e  = in_if.frame_start ? '0 : pcol_r;
  assign rsum_e = ((col_e == '0) ? '0 : rsum_r) + INT_W'(in_if.pixel);

  // this pixel completes integral entry (row+1, col+1)
  assign r1     = COORD_W'(cur_row_r) + 1'b1;
  assign c1     = COORD_W'(cur_col_r) + 1'b1;
  assign in_win = (r1 >= COORD_W'(size_e)) && (c1 >= COORD_W'(size_e));

  // ---------------------------------------------------------------- corner addressing
  assign def   = lobe_def(idx_r[5:2]);
  assign x_idx = idx_r[0] ? def.x2 : def.x1;
  assign y_idx = idx_r[1] ? def.y2 : def.y1;
  assign rrow  = top_r + COORD_W'(sc_yv);
  assign rcol  = left_r + COORD_W'(sc_xv);

  // corners a, b, c, d in order: a and d add, b and c subtract
  always_comb begin
    tag0        = '0;
    tag0.vld    = (state_r == S_READ);
    tag0.last   = (idx_r == 6'(NCORNERS - 1));
    tag0.zero   = (rrow == '0) || (rcol == '0);
    tag0.neg    = idx_r[0] ^ idx_r[1];
    tag0.corner = idx_r[1:0];
    tag0.lobe   = idx_r[5:2];
  end

  always_comb begin
    if (state_r == S_READ) begin
      ram_raddr = ram_addr(rrow, rcol);
    end else begin
      // entry above the one this pixel completes
      ram_raddr = ram_addr(COORD_W'(row_e), COORD_W'(col_e) + 1'b1);
    end
  end

  // integral row 0 reads as zero
  assign ram_we    = (state_r == S_WRITE);
  assign ram_waddr = ram_addr(r1, c1);
  assign ram_wdata = ((cur_row_r == '0) ? '0 : ram_rdata) + rsum_r;

  assign div_start = (state_r == S_WRITE) && in_win;

  // ---------------------------------------------------------------- main sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      prow_r  <= '0;
      pcol_r  <= '0;
      rsum_r  <= '0;
      idx_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            cur_row_r <= row_e;
            cur_col_r <= col_e;
            rsum_r    <= rsum_e;
            state_r   <= S_WRITE;
          end
        end
        S_WRITE: begin
          // advance the raster counters, a row or frame ends at the clamped size
          if (c1 >= width_e) begin
            pcol_r <= '0;
            prow_r <= (r1 >= height_e) ? '0 : r1[POS_W-1:0];
          end else begin
            pcol_r <= c1[POS_W-1:0];
            prow_r <= cur_row_r;
          end
          top_r   <= r1 - COORD_W'(size_e);
          left_r  <= c1 - COORD_W'(size_e);
          state_r <= in_win ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          if (rdiv_done) begin
            if (rrem == '0 && crem == '0) begin
              orow_r  <= POS_W'(mq + rq);
              ocol_r  <= POS_W'(mq + cq);
              idx_r   <= '0;
              state_r <= S_READ;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_READ: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r == 6'(NCORNERS - 1)) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (cvld_r && clast_r) begin
            state_r <= S_START;
          end
        end
        S_START: state_r <= S_DET;
        S_DET: begin
          if (det_done) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- box sums and weights
  assign term    = tag_a_r.zero ? '0 : ram_rdata;
  assign box_nxt = ((tag_a_r.corner == 2'd0) ? '0 : box_r) + (tag_a_r.neg ? -term : term);
  assign prod_ext = $signed(prod_r[ACC_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_a_r <= '0;
      bvld_r  <= 1'b0;
      cvld_r  <= 1'b0;
    end else begin
      tag_a_r <= tag0;
      bvld_r  <= tag_a_r.vld && (tag_a_r.corner == 2'd3);
      cvld_r  <= bvld_r;
    end
  end

  always_ff @(posedge clk) begin
    // stage a: read data back, box sum modulo 2^32
    if (tag_a_r.vld) begin
      box_r <= box_nxt;
    end
    blast_r <= tag_a_r.last;
    blobe_r <= tag_a_r.lobe;
    boxv_r  <= box_nxt;
    wt_b_r  <= wt;
    // stage b: weight the box
    prod_r  <= $signed({1'b0, boxv_r}) * wt_b_r;
    clast_r <= blast_r;
    clobe_r <= blobe_r;
    // stage c: accumulate per derivative
    if (state_r == S_DIV) begin
      acc_xx_r <= '0;
      acc_yy_r <= '0;
      acc_xy_r <= '0;
    end else if (cvld_r) begin
      if (clobe_r < 4'd3) begin
        acc_xx_r <= acc_xx_r + prod_ext;
      end else if (clobe_r < 4'd6) begin
        acc_yy_r <= acc_yy_r + prod_ext;
      end else begin
        acc_xy_r <= acc_xy_r + prod_ext;
      end
    end
  end

  function automatic logic signed [DERIV_W-1:0] sat_d(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    r = v;
    if (v > D_HI) begin
      r = D_HI;
    end else if (v < D_LO) begin
      r = D_LO;
    end
    return r[DERIV_W-1:0];
  endfunction

  assign det_start = (state_r == S_START);

  // ---------------------------------------------------------------- output register
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      det_q_r  <= det_v;
      tr_q_r   <= tr_v;
      orow_q_r <= orow_r;
      ocol_q_r <= ocol_r;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.det_response   = det_q_r;
  assign out_if.trace_response = tr_q_r;
  assign out_if.out_row        = orow_q_r;
  assign out_if.out_col        = ocol_q_r;

  // ---------------------------------------------------------------- submodules
  bhr_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // top / step and its remainder
  bhr_pdiv u_rdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (r1 - COORD_W'(size_e)),
    .divisor  (step_e),
    .done     (rdiv_done),
    .quo      (rq),
    .rem      (rrem)
  );

  // left / step and its remainder
  bhr_pdiv u_cdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (c1 - COORD_W'(size_e)),
    .divisor  (step_e),
    .done     (cdiv_done),
    .quo      (cq),
    .rem      (crem)
  );

  // margin: half the filter size in steps
  bhr_pdiv u_mdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (COORD_W'(size_e >> 1)),
    .divisor  (step_e),
    .done     (mdiv_done),
    .quo      (mq),
    .rem      (mrem)
  );

  bhr_pattern u_pattern (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (rebuild_r),
    .size   (size_e),
    .x_idx  (x_idx),
    .y_idx  (y_idx),
    .wt_idx (tag_a_r.lobe),
    .busy   (pat_busy),
    .sc_x   (sc_xv),
    .sc_y   (sc_yv),
    .wt     (wt)
  );

  bhr_det u_det (
    .clk   (clk),
    .rst_n (rst_n),
    .start (det_start),
    .dxx   (sat_d(acc_xx_r)),
    .dyy   (sat_d(acc_yy_r)),
    .dxy   (sat_d(acc_xy_r)),
    .done  (det_done),
    .det   (det_v),
    .trace (tr_v)
  );

  // the three dividers run in lockstep; only the row divider paces the sequencer
  logic div_sync_unused;
  assign div_sync_unused = cdiv_done ^ mdiv_done ^ (|mrem);

endmodule

`default_nettype wire

>>> rtl/core/bhr_checker.sv
// bhr_checker: port-level assertions for box_hessian_response, bound to the top level
// depends on bhr_pkg for widths and register indexes
`default_nettype none

module bhr_checker import bhr_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      cfg_we,
  input logic [1:0]                cfg_idx,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [DET_W-1:0]   det_response,
  input logic signed [TRACE_W-1:0] trace_response,
  input logic [POS_W-1:0]          out_row,
  input logic [POS_W-1:0]          out_col
);

  // a response waits until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("response dropped while stalled");

  // a stalled response keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(det_response) && $stable(trace_response)
      && $stable(out_row) && $stable(out_col))
    else $error("response payload changed while stalled");

  // one pixel at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("pixel taken while the previous one is in work");

  // a new filter size blocks intake while the pattern is rebuilt
  a_rebuild_block: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_idx == CFG_FILTER_SIZE) |=> !in_ready)
    else $error("pixel taken during pattern rebuild");

  // no response appears the cycle after a pixel is taken
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("response too early");

endmodule

bind box_hessian_response bhr_checker u_bhr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .cfg_we         (cfg_we),
  .cfg_idx        (cfg_idx),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .det_response   (out_if.det_response),
  .trace_response (out_if.trace_response),
  .out_row        (out_if.out_row),
  .out_col        (out_if.out_col)
);

`default_nettype wire

>>> verif/tb_box_hessian_response.sv
// tb_box_hessian_response: self-checking testbench of the streaming box hessian response block
// depends on bhr_pkg, bhr_if and the box_hessian_response rtl
`default_nettype none

module tb_box_hessian_response;
  import bhr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 1650;
  localparam int HOLD_CYCLES = 800;
  localparam int SETTLE_CYCLES = 120;

  // one response as it leaves the block
  typedef struct {
    logic [DET_W-1:0]   det;
    logic [TRACE_W-1:0] trace;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
  } response_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [1:0]       cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  bhr_in_if  pix_ch ();
  bhr_out_if resp_ch ();

  box_hessian_response DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_we (cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_data(cfg_data),
    .in_if  (pix_ch),
    .out_if (resp_ch)
  );

  // responses still owed by the block, oldest first
  response_t pending_resp[$];
  int        mismatches;
  int        pixels_sent;
  bit        hold_req;
  int        hold_cnt;

  // shadow of the block: configuration, integral store, counters, pattern
  int unsigned sh_size, sh_step, sh_width, sh_height;
  int unsigned integ_store[STORE_DEPTH];
  int unsigned row_sum, cur_row, cur_col;
  int unsigned corner_tab[NCORNERS];
  int          weight_tab[NLOBES];

  // 9x9 base lobes: x1, y1, x2, y2, signed weight
  int base_lobe[NLOBES][5] = '{
    '{0, 2, 3, 7, 1}, '{3, 2, 6, 7, -2}, '{6, 2, 9, 7, 1},
    '{2, 0, 7, 3, 1}, '{2, 3, 7, 6, -2}, '{2, 6, 7, 9, 1},
    '{1, 1, 4, 4, 1}, '{5, 1, 8, 4, -1}, '{1, 5, 4, 8, -1}, '{5, 5, 8, 8, 1}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #100ms;
    $display("box_hessian_response test failed");
    $finish;
  end

  // ---------------------------------------------------------------- shadow model

  function automatic int unsigned box_size();
    int unsigned s;
    s = sh_size;
    if (s < BASE_SIZE) s = BASE_SIZE;
    if (s > MAX_SIZE) s = MAX_SIZE;
    return s;
  endfunction

  function automatic int unsigned samp_step();
    return (sh_step == 0) ? 1 : sh_step;
  endfunction

  function automatic int unsigned row_len();
    int unsigned w;
    w = sh_width;
    if (w < 2) w = 2;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (w > 1024) w = 1024;
    return w;
  endfunction

  function automatic int unsigned frame_rows();
    int unsigned h;
    h = sh_height;
    if (h < 2) h = 2;
    if (h > 1024) h = 1024;
    return h;
  endfunction

  // rescale the corners from the 9x9 pattern, weights are rounded q16 reciprocals of the area
  function automatic void rescale_pattern();
    int unsigned s, wd, ht, area, mag;
    int          q;
    s = box_size();
    for (int k = 0; k < NLOBES; k++) begin
      for (int i = 0; i < 4; i++)
        corner_tab[4*k+i] = int'(base_lobe[k][i]) * s / BASE_SIZE;
      wd   = corner_tab[4*k+2] - corner_tab[4*k];
      ht   = corner_tab[4*k+3] - corner_tab[4*k+1];
      area = wd * ht;
      mag  = (base_lobe[k][4] < 0) ? -base_lobe[k][4] : base_lobe[k][4];
      q    = (area != 0) ? int'((131072 * mag + area) / (2 * area)) : 0;
      weight_tab[k] = (base_lobe[k][4] < 0) ? -q : q;
    end
  endfunction

  // integral row 0 and column 0 are zero and never stored
  function automatic int unsigned integ_at(int unsigned r, int unsigned c);
    if (r == 0 || c == 0 || c > MAX_WIDTH) return 0;
    return integ_store[(r % WINDOW_ROWS) * ROW_PITCH + c];
  endfunction

  function automatic longint clamp(longint v, longint hi);
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // weighted sum of lobe boxes in q16, saturated to the derivative width
  function automatic longint lobe_sum(int first, int count, int unsigned top,
                                      int unsigned left);
    longint      acc;
    int unsigned a, b, c, d, box;
    acc = 0;
    for (int k = first; k < first + count; k++) begin
      a = integ_at(top + corner_tab[4*k+1], left + corner_tab[4*k]);
      b = integ_at(top + corner_tab[4*k+1], left + corner_tab[4*k+2]);
      c = integ_at(top + corner_tab[4*k+3], left + corner_tab[4*k]);
      d = integ_at(top + corner_tab[4*k+3], left + corner_tab[4*k+2]);
      box = a + d - b - c;
      acc += longint'(box) * longint'(weight_tab[k]);
    end
    return clamp(acc, 64'sd134217727);
  endfunction

  // advance the shadow by one accepted pixel and queue the response it causes
  function automatic void predict_pixel(logic [PIX_W-1:0] pix, logic fs);
    int unsigned r1, c1, s, st, top, left, margin;
    longint      dxx, dyy, dxy, t, det, tr;
    response_t   e;
    if (fs) begin
      cur_row = 0;
      cur_col = 0;
    end
    if (cur_col == 0) row_sum = 0;
    row_sum += pix;
    r1 = cur_row + 1;
    c1 = cur_col + 1;
    if (c1 <= MAX_WIDTH)
      integ_store[(r1 % WINDOW_ROWS) * ROW_PITCH + c1] = integ_at(cur_row, c1) + row_sum;
    s  = box_size();
    st = samp_step();
    if (r1 >= s && c1 >= s) begin
      top  = r1 - s;
      left = c1 - s;
      if (top % st == 0 && left % st == 0) begin
        dxx = lobe_sum(0, 3, top, left);
        dyy = lobe_sum(3, 3, top, left);
        dxy = lobe_sum(6, 4, top, left);
        t   = ((dxy * dxy) >>> 16) * longint'(K081_Q16);
        det = (dxx * dyy - t + (64'sd1 <<< 19)) >>> 20;
        det = clamp(det, 64'sd17179869183);
        tr  = clamp(dxx + dyy, 64'sd268435455);
        margin  = (s / 2) / st;
        e.det   = det[DET_W-1:0];
        e.trace = tr[TRACE_W-1:0];
        e.row   = POS_W'(margin + top / st);
        e.col   = POS_W'(margin + left / st);
        pending_resp.push_back(e);
      end
    end
    if (cur_col + 1 >= row_len()) begin
      cur_col = 0;
      cur_row = (cur_row + 1 >= frame_rows()) ? 0 : cur_row + 1;
    end else begin
      cur_col++;
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  // mostly back to back, some short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one pixel, called and returning at a falling edge
  task automatic send_pixel(logic [PIX_W-1:0] pix, logic fs);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      pix_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_ch.valid       = 1'b1;
    pix_ch.pixel       = pix;
    pix_ch.frame_start = fs;
    forever begin
      @(posedge clk);
      if (pix_ch.ready) break;
    end
    predict_pixel(pix, fs);
    pixels_sent++;
    @(negedge clk);
  endtask

  // a frame's worth of random pixels; noise sets the odds of a stray frame start
  task automatic send_frame(int count, int noise);
    for (int i = 0; i < count; i++)
      send_pixel(PIX_W'($urandom), (i == 0) || (noise > 0 && $urandom_range(1, noise) == 1));
  endtask

  // wait until every owed response is in and the block has gone quiet
  task automatic drain();
    pix_ch.valid = 1'b0;
    while (pending_resp.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // register write, only while idle
  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_FILTER_SIZE: begin
        sh_size = val & 8'hFF;
        rescale_pattern();
      end
      CFG_SAMPLE_STEP:  sh_step   = val & 5'h1F;
      CFG_IMAGE_WIDTH:  sh_width  = val & 11'h7FF;
      CFG_IMAGE_HEIGHT: sh_height = val & 11'h7FF;
      default: ;
    endcase
  endtask

  task automatic set_geometry(logic [CFG_W-1:0] size, logic [CFG_W-1:0] step,
                              logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    drain();
    write_reg(CFG_FILTER_SIZE, size);
    write_reg(CFG_SAMPLE_STEP, step);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
  endtask

  // ---------------------------------------------------------------- response side

  // ready with random gaps, plus one long hold on request
  initial begin
    resp_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        resp_ch.ready = 1'b0;
        hold_cnt = 0;
        while (hold_cnt < HOLD_CYCLES) begin
          @(negedge clk);
          hold_cnt++;
        end
        hold_req = 1'b0;
        resp_ch.ready = 1'b1;
      end else begin
        resp_ch.ready = (idle_len() == 0);
      end
    end
  end

  // compare each response transaction with the oldest prediction
  always @(posedge clk) begin
    response_t e;
    if (rst_n && resp_ch.valid && resp_ch.ready) begin
      if (pending_resp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response det=%0d trace=%0d row=%0d col=%0d",
                   resp_ch.det_response, resp_ch.trace_response,
                   resp_ch.out_row, resp_ch.out_col);
      end else begin
        e = pending_resp.pop_front();
        if (resp_ch.det_response !== e.det || resp_ch.trace_response !== e.trace ||
            resp_ch.out_row !== e.row || resp_ch.out_col !== e.col) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp det=%0d trace=%0d row=%0d col=%0d, got det=%0d trace=%0d row=%0d col=%0d",
                     $signed(e.det), $signed(e.trace), e.row, e.col,
                     resp_ch.det_response, resp_ch.trace_response,
                     resp_ch.out_row, resp_ch.out_col);
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // reset defaults, no window completes on a 640 wide image this early
  task automatic test_reset_defaults();
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd255, 1'b1);
    for (int i = 0; i < 12; i++) send_pixel((i % 2) ? 8'd255 : 8'd0, 1'b0);
  endtask

  // all-white then all-black frames on the base size, then an extreme-valued frame
  task automatic test_extremes();
    set_geometry(9, 1, 10, 10);
    for (int i = 0; i < 100; i++) send_pixel(8'd255, i == 0);
    for (int i = 0; i < 100; i++) send_pixel(8'd0, i == 0);
    for (int i = 0; i < 100; i++) send_pixel(($urandom_range(0, 1)) ? 8'd255 : 8'd0, i == 0);
  endtask

  // sizes and step out of range: low clamps up, high clamps to the window, zero step is one
  task automatic test_clamps();
    set_geometry(3, 0, 11, 11);
    send_frame(121, 0);
    set_geometry(11'h7FF, 16, 63, 63);
    send_frame(63 * 63, 0);
  endtask

  // frames that wrap without frame start, and a width clamped to the store
  task automatic test_frame_wrap();
    set_geometry(9, 2, 12, 10);
    send_frame(3 * 120 + 17, 0);
    set_geometry(9, 1, 11'h7FF, 0);
    send_frame(1030, 0);
    set_geometry(12, 3, 2, 1);
    send_frame(30, 0);
  endtask

  // hold off the receiver long enough for the block to back up into its input
  task automatic test_backpressure();
    set_geometry(9, 1, 12, 12);
    hold_req = 1'b1;
    send_frame(144, 0);
  endtask

  // random geometries, mostly clean frames, some stray frame starts
  task automatic test_random();
    int unsigned sz, st, w, h, n;
    while (pixels_sent < ITEM_TARGET + 6000) begin
      sz = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 30) : $urandom_range(9, 13);
      st = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 3);
      w  = sz + $urandom_range(0, 6);
      h  = sz + $urandom_range(0, 4);
      n  = w * h + $urandom_range(0, w * h);
      set_geometry(sz, st, w, h);
      send_frame(n, ($urandom_range(0, 3) == 0) ? 60 : 0);
    end
  endtask

  // ---------------------------------------------------------------- main sequence

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = CFG_FILTER_SIZE;
    cfg_data           = '0;
    pix_ch.valid       = 1'b0;
    pix_ch.pixel       = '0;
    pix_ch.frame_start = 1'b0;
    mismatches  = 0;
    pixels_sent = 0;
    hold_req    = 1'b0;
    sh_size   = 9;
    sh_step   = 1;
    sh_width  = 640;
    sh_height = 480;
    row_sum = 0;
    cur_row = 0;
    cur_col = 0;
    rescale_pattern();
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_extremes();
    test_clamps();
    test_frame_wrap();
    test_backpressure();
    test_random();

    drain();
    repeat (200) @(negedge clk);
    if (mismatches == 0 && pending_resp.size() == 0) begin
      $display("box_hessian_response test passed");
    end else begin
      $display("box_hessian_response test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
rtl/core/bhr_pkg.sv
rtl/core/bhr_if.sv
rtl/core/bhr_ram.sv
rtl/core/bhr_pdiv.sv
rtl/core/bhr_pattern.sv
rtl/core/bhr_det.sv
rtl/core/box_hessian_response.sv
rtl/core/bhr_checker.sv
verif/tb_box_hessian_response.sv
